>>> rtl/mau_pkg.sv
package mau_pkg;

	localparam int unsigned OP_W  = 32;
	localparam int unsigned MOD_W = 30;
	localparam int unsigned CMD_W = 3;

	localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(1000000007);

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MUL   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POW   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DIV   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_BINOM = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [OP_W-1:0]  operand_a;
		logic [OP_W-1:0]  operand_b;
	} in_item_t;

	typedef struct packed {
		logic [MOD_W-1:0] result;
		logic             range_error;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_RED_A,
		ST_RED_B,
		ST_ADDSUB,
		ST_PW_STEP,
		ST_PW_ACC,
		ST_PW_SQ,
		ST_FINAL,
		ST_BN_STEP,
		ST_BN_NUM,
		ST_BN_DEN,
		ST_OUT
	} state_t;

endpackage

>>> rtl/modular_arithmetic_unit_core.sv
// Modular arithmetic unit: one transaction carries a command (add, sub, mul, pow, div by
// Fermat inverse, binomial C(a,b)) and two 32-bit operands; one 30-bit result comes back,
// reduced modulo the modulus register (reset 1000000007, prime for div and binomial).
// Products and operand reductions run through a single bit-serial modular multiplier: a
// sequencer state launches a product, the multiplier does one shift-add-reduce step per
// bit of its 32-bit x operand, and the return state takes the product and may launch
// the next one. Add and sub use a separate adder once both operands are reduced.
// Pow uses b as the exponent; div and binomial invert through the exponent m-2.
// Commands 6 and 7, a modulus below two, or a binomial with b above MAX_K give result 0
// without running the multiplier (range_error set for the last case).
// The input stalls for the whole transaction; a finished result waits in an output
// register so the next transaction can be taken while it is pending. The input is
// released in the same cycle that out_valid rises.
module modular_arithmetic_unit_core #(
	parameter int unsigned MAX_K = 4095
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [mau_pkg::MOD_W-1:0]   cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  mau_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output mau_pkg::out_item_t          out_data
);
	import mau_pkg::*;

	localparam int unsigned KW = $clog2(MAX_K + 1);

	state_t state_q, state_d, ret_q;

	logic [MOD_W-1:0] mod_q;
	logic [CMD_W-1:0] cmd_q;
	logic [MOD_W-1:0] ar_q, br_q, acc_q, base_q, num_q, den_q, im_q;
	logic [OP_W-1:0]  b_q, e_q;
	logic [KW-1:0]    kcnt_q;
	logic [MOD_W-1:0] res_q;
	logic             err_q;
	logic             out_valid_q;
	out_item_t        out_q;

	// shared multiplier registers
	logic [OP_W-1:0]  mx_q;
	logic [MOD_W-1:0] my_q, macc_q;
	logic [4:0]       mcnt_q;

	// multiplier launch request
	logic             mul_go;
	logic [OP_W-1:0]  mul_x;
	logic [MOD_W-1:0] mul_y;
	state_t           mul_ret;

	logic             in_err;
	logic             out_free;
	logic [OP_W-1:0]  mt, mt_sub1, mt_sub2;
	logic [MOD_W:0]   dfac_w, sum_w, sum_red;
	logic [MOD_W-1:0] dfac, term;

	assign in_err   = (in_data.cmd == CMD_BINOM) && (in_data.operand_b > OP_W'(MAX_K));
	assign out_free = !out_valid_q || !out_stall;

	// one multiplier step: acc = (2*acc + bit*y) mod m
	assign mt      = {1'b0, macc_q, 1'b0} + (mx_q[OP_W-1] ? OP_W'(my_q) : '0);
	assign mt_sub1 = mt - OP_W'(mod_q);
	assign mt_sub2 = mt - {1'b0, mod_q, 1'b0};

	// binomial factors: (i+1) mod m and (n - i) mod m
	assign dfac_w = {1'b0, im_q} + (MOD_W+1)'(1);
	assign dfac   = (dfac_w == {1'b0, mod_q}) ? '0 : dfac_w[MOD_W-1:0];
	assign term   = (ar_q >= im_q) ? (ar_q - im_q) : (ar_q + mod_q - im_q);

	// add / sub with a single correction
	always_comb begin
		if (cmd_q == CMD_SUB) begin
			sum_w = {1'b0, ar_q} + {1'b0, mod_q} - {1'b0, br_q};
		end else begin
			sum_w = {1'b0, ar_q} + {1'b0, br_q};
		end
		sum_red = (sum_w >= {1'b0, mod_q}) ? (sum_w - {1'b0, mod_q}) : sum_w;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_go  = 1'b0;
		mul_x   = '0;
		mul_y   = '0;
		mul_ret = ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_err || mod_q < MOD_W'(2) || in_data.cmd > CMD_BINOM) begin
						state_d = ST_OUT;
					end else begin
						mul_go  = 1'b1;
						mul_x   = in_data.operand_a;
						mul_y   = MOD_W'(1);
						mul_ret = ST_RED_A;
					end
				end
			end
			ST_MUL: begin
				if (mcnt_q == '0) state_d = ret_q;
			end
			ST_RED_A: begin
				mul_go  = 1'b1;
				mul_x   = b_q;
				mul_y   = MOD_W'(1);
				mul_ret = ST_RED_B;
			end
			ST_RED_B: begin
				priority case (cmd_q)
					CMD_ADD, CMD_SUB: state_d = ST_ADDSUB;
					CMD_MUL: begin
						mul_go  = 1'b1;
						mul_x   = OP_W'(ar_q);
						mul_y   = macc_q;
						mul_ret = ST_FINAL;
					end
					CMD_POW, CMD_DIV: state_d = ST_PW_STEP;
					default:          state_d = ST_BN_STEP;
				endcase
			end
			ST_ADDSUB: state_d = ST_OUT;
			ST_PW_STEP: begin
				if (e_q == '0) begin
					if (cmd_q == CMD_POW) begin
						state_d = ST_OUT;
					end else begin
						mul_go  = 1'b1;
						mul_x   = OP_W'(ar_q);
						mul_y   = acc_q;
						mul_ret = ST_FINAL;
					end
				end else if (e_q[0]) begin
					mul_go  = 1'b1;
					mul_x   = OP_W'(acc_q);
					mul_y   = base_q;
					mul_ret = ST_PW_ACC;
				end else begin
					mul_go  = 1'b1;
					mul_x   = OP_W'(base_q);
					mul_y   = base_q;
					mul_ret = ST_PW_SQ;
				end
			end
			ST_PW_ACC: begin
				mul_go  = 1'b1;
				mul_x   = OP_W'(base_q);
				mul_y   = base_q;
				mul_ret = ST_PW_SQ;
			end
			ST_PW_SQ:  state_d = ST_PW_STEP;
			ST_FINAL:  state_d = ST_OUT;
			ST_BN_STEP: begin
				if (kcnt_q == b_q[KW-1:0]) begin
					state_d = ST_PW_STEP;
				end else begin
					mul_go  = 1'b1;
					mul_x   = OP_W'(num_q);
					mul_y   = term;
					mul_ret = ST_BN_NUM;
				end
			end
			ST_BN_NUM: begin
				mul_go  = 1'b1;
				mul_x   = OP_W'(den_q);
				mul_y   = dfac;
				mul_ret = ST_BN_DEN;
			end
			ST_BN_DEN: state_d = ST_BN_STEP;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (mul_go) state_d = ST_MUL;
	end

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MODULUS_RESET;
		end else if (cfg_wr_en) begin
			mod_q <= cfg_wr_data;
		end
	end

	// shared modular multiplier
	always_ff @(posedge clk) begin
		if (mul_go) begin
			mx_q   <= mul_x;
			my_q   <= mul_y;
			macc_q <= '0;
			mcnt_q <= 5'd31;
			ret_q  <= mul_ret;
		end else if (state_q == ST_MUL) begin
			mx_q   <= {mx_q[OP_W-2:0], 1'b0};
			mcnt_q <= mcnt_q - 5'd1;
			if (!mt_sub2[OP_W-1] && mt >= {1'b0, mod_q, 1'b0}) begin
				macc_q <= mt_sub2[MOD_W-1:0];
			end else if (mt >= OP_W'(mod_q)) begin
				macc_q <= mt_sub1[MOD_W-1:0];
			end else begin
				macc_q <= mt[MOD_W-1:0];
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q <= in_data.cmd;
				b_q   <= in_data.operand_b;
				res_q <= '0;
				err_q <= in_err;
			end
			ST_RED_A: ar_q <= macc_q;
			ST_RED_B: begin
				br_q   <= macc_q;
				acc_q  <= MOD_W'(1);
				num_q  <= MOD_W'(1);
				den_q  <= MOD_W'(1);
				im_q   <= '0;
				kcnt_q <= '0;
				if (cmd_q == CMD_POW) begin
					base_q <= ar_q;
					e_q    <= b_q;
				end else begin
					base_q <= macc_q;
					e_q    <= OP_W'(mod_q) - OP_W'(2);
				end
			end
			ST_ADDSUB: res_q <= sum_red[MOD_W-1:0];
			ST_PW_STEP: begin
				if (e_q == '0) res_q <= acc_q;
			end
			ST_PW_ACC: acc_q <= macc_q;
			ST_PW_SQ: begin
				base_q <= macc_q;
				e_q    <= e_q >> 1;
			end
			ST_FINAL: res_q <= macc_q;
			ST_BN_STEP: begin
				// loop done: num becomes the final factor, den^(m-2) follows
				if (kcnt_q == b_q[KW-1:0]) begin
					ar_q   <= num_q;
					base_q <= den_q;
					acc_q  <= MOD_W'(1);
					e_q    <= OP_W'(mod_q) - OP_W'(2);
				end
			end
			ST_BN_NUM: num_q <= macc_q;
			ST_BN_DEN: begin
				den_q  <= macc_q;
				im_q   <= dfac;
				kcnt_q <= kcnt_q + KW'(1);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_q.result      <= res_q;
			out_q.range_error <= err_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a range error always carries a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.range_error && out_data.result != '0))
		else $error("range_error with nonzero result");

	// results stay reduced
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && mod_q >= MOD_W'(2)) |-> (out_data.result < mod_q))
		else $error("result not reduced");

	// multiplier accumulator stays below the modulus
	a_macc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (macc_q < mod_q))
		else $error("multiplier accumulator out of range");

	// a multiply always ends after its step count
	a_mul_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && mcnt_q == '0) |=> (state_q != ST_MUL || mcnt_q == 5'd31))
		else $error("multiplier overran");

endmodule

>>> tb/mau_checker.sv
`timescale 1ns / 100ps

module mau_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [mau_pkg::MOD_W-1:0]   cfg_wr_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  mau_pkg::in_item_t           in_data,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  mau_pkg::out_item_t          out_data,
	output int                          errors,
	output int                          pending,
	output int                          checked
);
	import mau_pkg::*;

	localparam longint unsigned BINOM_K_MAX = 4095;

	logic [MOD_W-1:0] cur_modulus;
	out_item_t        result_fifo[$];

	function automatic longint unsigned mul_mod(longint unsigned x, longint unsigned y,
			longint unsigned m);
		return (x * y) % m;
	endfunction

	// square-and-multiply; exponent is used unreduced
	function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned ex,
			longint unsigned m);
		longint unsigned acc;
		acc = 1 % m;
		base = base % m;
		while (ex != 0) begin
			if (ex[0])
				acc = mul_mod(acc, base, m);
			base = mul_mod(base, base, m);
			ex = ex >> 1;
		end
		return acc;
	endfunction

	// quotient through the Fermat inverse, applied even for non-prime m
	function automatic longint unsigned div_mod(longint unsigned x, longint unsigned y,
			longint unsigned m);
		return mul_mod(x % m, pow_mod(y, m - 2, m), m);
	endfunction

	function automatic out_item_t predict_result(in_item_t it, logic [MOD_W-1:0] mod_reg);
		longint unsigned m, ar, br, kk, res, num, den, term;
		out_item_t r;
		m   = mod_reg;
		kk  = it.operand_b;
		res = 0;
		r.range_error = (it.cmd == CMD_BINOM) && (kk > BINOM_K_MAX);
		if (m >= 2 && !r.range_error) begin
			ar = it.operand_a % m;
			br = it.operand_b % m;
			case (it.cmd)
				CMD_ADD: res = (ar + br) % m;
				CMD_SUB: res = (ar + m - br) % m;
				CMD_MUL: res = mul_mod(ar, br, m);
				CMD_POW: res = pow_mod(ar, kk, m);
				CMD_DIV: res = div_mod(ar, br, m);
				CMD_BINOM: begin
					// falling factorial over k!
					num = 1 % m;
					den = 1 % m;
					for (longint unsigned i = 0; i < kk; i++) begin
						term = (ar + m - (i % m)) % m;
						num  = mul_mod(num, term, m);
						den  = mul_mod(den, (i + 1) % m, m);
					end
					res = div_mod(num, den, m);
				end
				default: res = 0;
			endcase
		end
		r.result = res[MOD_W-1:0];
		return r;
	endfunction

	assign pending = result_fifo.size();

	// track modulus writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cur_modulus <= MODULUS_RESET;
		else if (cfg_wr_en)
			cur_modulus <= cfg_wr_data;
	end

	// predict on input transactions, compare on output transactions
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n) begin
			if (in_valid && !in_stall)
				result_fifo.push_back(predict_result(in_data, cur_modulus));
			if (out_valid && !out_stall) begin
				checked++;
				if (result_fifo.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h/%b", $time, out_data.result,
						out_data.range_error);
				end else begin
					exp_r = result_fifo.pop_front();
					if (exp_r.result !== out_data.result) begin
						errors++;
						$display("%0t: result mismatch expected %0d actual %0d", $time,
							exp_r.result, out_data.result);
					end
					if (exp_r.range_error !== out_data.range_error) begin
						errors++;
						$display("%0t: range_error mismatch expected %b actual %b", $time,
							exp_r.range_error, out_data.range_error);
					end
				end
			end
		end
	end

	initial begin
		errors  = 0;
		checked = 0;
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import mau_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
	localparam int IDLE_LIMIT = 1500000;
	localparam int N_RANDOM   = 200;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [MOD_W-1:0] cfg_wr_data;
	logic             in_valid;
	logic             in_stall;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_stall;
	out_item_t        out_data;
	int               errors, pending, checked;
	int               idle_cycles;
	int               sent;
	int               n_settings;
	bit               hold_req;

	logic [MOD_W-1:0] modulus_list[9] = '{30'd2, 30'd3, 30'd7, 30'd0, 30'd1,
		30'd1073741823, 30'd1073741789, 30'd65537, MODULUS_RESET};

	modular_arithmetic_unit_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	mau_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.errors(errors), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// mostly short gaps, sometimes long
	function automatic int gap_len();
		int sel;
		sel = $urandom_range(0, 15);
		if (sel < 7) return 0;
		if (sel < 14) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// one input transaction; valid stays up across back-to-back items
	task automatic send(logic [CMD_W-1:0] c, logic [OP_W-1:0] a, logic [OP_W-1:0] b);
		bit acc;
		int g;
		in_data  <= '{cmd: c, operand_a: a, operand_b: b};
		in_valid <= 1'b1;
		forever begin
			#1;
			acc = !in_stall;
			@(posedge clk);
			if (acc) break;
			@(negedge clk);
		end
		sent++;
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_modulus(logic [MOD_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [OP_W-1:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return '1;
			1: return $urandom_range(0, 16);
			2: return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random();
		logic [CMD_W-1:0] c;
		logic [OP_W-1:0]  a, b;
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 18) c = CMD_W'(sel / 3);
		else c = (sel == 18) ? CMD_RSVD6 : CMD_RSVD7;
		a = rand_operand();
		b = rand_operand();
		if (c == CMD_BINOM) begin
			// keep k small: binomial runtime grows with k
			case ($urandom_range(0, 9))
				0: b = $urandom;
				1: b = $urandom_range(16, 120);
				default: b = $urandom_range(0, 15);
			endcase
		end
		send(c, a, b);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int len;
		bit busy_mode;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				busy_mode = ($urandom_range(0, 7) != 0);
				len = $urandom_range(0, 3) == 0 ? $urandom_range(10, 80)
					: $urandom_range(1, 6);
				out_stall <= busy_mode && ($urandom_range(0, 2) == 0);
				repeat (len - 1) begin
					@(negedge clk);
					if (!hold_req)
						out_stall <= busy_mode && ($urandom_range(0, 2) == 0);
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		hold_req    = 1'b0;
		idle_cycles = 0;
		sent        = 0;
		n_settings  = 1;
		arst_n      = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed at the reset modulus
		send(CMD_ADD, '1, '1);
		send(CMD_ADD, 0, 0);
		send(CMD_SUB, 0, 1);
		send(CMD_SUB, 32'd5, '1);
		send(CMD_MUL, '1, '1);
		send(CMD_MUL, 32'd1000000006, 32'd1000000006);
		send(CMD_POW, 32'd7, 0);
		send(CMD_POW, 0, 0);
		send(CMD_POW, '1, '1);
		send(CMD_POW, 32'd2, 32'd1000000006);
		send(CMD_DIV, 32'd10, 0);
		send(CMD_DIV, 32'd10, 32'd1000000007);
		send(CMD_DIV, 32'd1, 32'd3);
		send(CMD_DIV, '1, '1);
		send(CMD_BINOM, 32'd10, 0);
		send(CMD_BINOM, 32'd10, 32'd1);
		send(CMD_BINOM, 32'd3, 32'd5);
		send(CMD_BINOM, '1, 32'd4095);
		send(CMD_BINOM, 32'd100, 32'd4096);
		send(CMD_BINOM, 32'd100, '1);
		send(CMD_RSVD6, '1, '1);
		send(CMD_RSVD7, 32'd3, 32'd4);

		// fill the block while the receiver holds off
		hold_req = 1'b1;
		repeat (6) send(CMD_ADD, $urandom, $urandom);
		drain();

		for (int p = 0; p < 9; p++) begin
			write_modulus(modulus_list[p]);
			for (int i = 0; i < N_RANDOM; i++) begin
				send_random();
				if (p == 1 && i == 50) begin
					hold_req = 1'b1;
				end
				if (p == 2 && i == 80) begin
					// sender pauses until everything has come back
					in_valid <= 1'b0;
					wait (pending == 0);
					@(negedge clk);
				end
			end
			if (modulus_list[p] == 30'd7)
				send(CMD_BINOM, 32'd20, 32'd9);
			drain();
		end

		repeat (100) @(negedge clk);
		$display("Covered %0d transactions over %0d modulus settings, %0d results checked.",
			sent, n_settings, checked);
		$display("Included stalls, a long output hold-off and out-of-range binomials.");
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> modular_arithmetic_unit_core.f
rtl/mau_pkg.sv
rtl/modular_arithmetic_unit_core.sv
tb/mau_checker.sv
tb/tb_top.sv
